// ----- hw/rtl/swqt_pkg.sv -----
// Shared types and constants for the semaphore wait-queue table.
package swqt_pkg;

  localparam int unsigned DefNumProcs = 16;
  localparam int unsigned OpW         = 2;
  localparam int unsigned KeyW        = 32;
  localparam int unsigned PidW        = 4;
  localparam int unsigned InDataW     = 40;
  localparam int unsigned OutDataW    = 8;

  typedef enum logic [OpW-1:0] {
    OP_INSERT = 2'd0,
    OP_TAKE   = 2'd1,
    OP_REMOVE = 2'd2,
    OP_PEEK   = 2'd3
  } op_e;

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_SCAN  = 7'b0000010,
    ST_TAIL  = 7'b0000100,
    ST_DESC  = 7'b0001000,
    ST_HT    = 7'b0010000,
    ST_HEAD  = 7'b0100000,
    ST_WALK  = 7'b1000000
  } state_e;

  typedef struct packed {
    logic [PidW-1:0] proc_out;
    logic            found;
    logic            refused;
  } result_t;

endpackage

// ----- hw/rtl/swqt_keymem.sv -----
// Descriptor key store with a registered read port and the shared key comparator.
module swqt_keymem
  import swqt_pkg::*;
#(
  parameter int unsigned NUM_PROCS = DefNumProcs,
  parameter int unsigned IW        = $clog2(NUM_PROCS)
) (
  input  logic            clk_i,
  input  logic            we_i,
  input  logic [IW-1:0]   wa_i,
  input  logic [KeyW-1:0] wd_i,
  input  logic [IW-1:0]   ra_i,
  input  logic [KeyW-1:0] cmp_i,
  output logic            eq_o
);

  logic [KeyW-1:0] mem_q [NUM_PROCS];
  logic [KeyW-1:0] rd_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[wa_i] <= wd_i;
    end
    rd_q <= mem_q[ra_i];
  end

  assign eq_o = (rd_q == cmp_i);

endmodule

// ----- hw/rtl/semaphore_wait_queue_table.sv -----
// Top level of the semaphore wait-queue table: sequencer, queue stores and stream ports.
//
//  channel   | dir | fields (low bit up)
//  s_axis    | in  | operation[1:0], sem_key[33:2], proc_id[37:34]
//  m_axis    | out | refused[0], found[1], proc_out[5:2]
//
// One beat is taken at a time. Insert, remove and peek scan the descriptors one per
// cycle through the key comparator; take and remove walk the queue one link per
// cycle.
// The result sits in an output register; no new beat is taken until it is consumed.
// Reset clears the in-use and blocked flags; the other stores need no clearing.
module semaphore_wait_queue_table
  import swqt_pkg::*;
#(
  parameter int unsigned NUM_PROCS = DefNumProcs
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  // operation[1:0], sem_key[33:2], proc_id[37:34], zero fill
  input  logic [InDataW-1:0]  s_axis_tdata_i,
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  // refused[0], found[1], proc_out[5:2], zero fill
  output logic [OutDataW-1:0] m_axis_tdata_o
);

  localparam int unsigned IW = $clog2(NUM_PROCS);
  localparam logic [IW-1:0] LastIdx = IW'(NUM_PROCS - 1);

  state_e state_q, state_d;
  op_e op_q, op_d, s_op;
  logic [KeyW-1:0] key_q, s_key;
  logic [PidW-1:0] s_pid;
  logic [IW-1:0] pid_q, pid_d, s_pidx;
  logic s_pid_ok;
  logic [IW-1:0] d_q, d_d, p_q, p_d, pred_q, pred_d, scan_q, scan_d, free_q, free_d;
  logic free_vld_q, free_vld_d;

  logic [NUM_PROCS-1:0] in_use_q, blocked_q;
  logic in_use_set, in_use_clr, blk_set, blk_clr;
  logic [IW-1:0] in_use_idx, blk_idx;

  logic [IW-1:0] head_mem [NUM_PROCS];
  logic [IW-1:0] tail_mem [NUM_PROCS];
  logic [IW-1:0] next_mem [NUM_PROCS];
  logic [IW-1:0] pdi_mem  [NUM_PROCS];
  logic [IW-1:0] head_rd_q, tail_rd_q, nxa_rd_q, nxb_rd_q, pdi_rd_q;
  logic [IW-1:0] d_ra, nxa_ra, nxb_ra, pid_ra, key_ra;
  logic head_we, tail_we, next_we, pdi_we, key_we;
  logic [IW-1:0] head_wa, head_wd, tail_wa, tail_wd, next_wa, next_wd, pdi_wa, pdi_wd, key_wa;
  logic key_eq;

  result_t res_q, res_d;
  logic out_vld_q, out_set;
  logic accept, hit, free_here;
  logic [IW-1:0] fidx, pn;

  assign s_op   = op_e'(s_axis_tdata_i[1:0]);
  assign s_key  = s_axis_tdata_i[33:2];
  assign s_pid  = s_axis_tdata_i[37:34];
  assign s_pidx = IW'(s_pid);
  assign s_pid_ok = 32'(s_pid) < NUM_PROCS;

  assign s_axis_tready_o = (state_q == ST_IDLE) && !out_vld_q;
  assign accept = s_axis_tvalid_i && s_axis_tready_o;

  swqt_keymem #(.NUM_PROCS(NUM_PROCS), .IW(IW)) u_keymem (
    .clk_i (clk_i),
    .we_i  (key_we),
    .wa_i  (key_wa),
    .wd_i  (key_q),
    .ra_i  (key_ra),
    .cmp_i (key_q),
    .eq_o  (key_eq)
  );

  assign hit       = in_use_q[scan_q] && key_eq;
  assign free_here = !in_use_q[scan_q];
  assign fidx      = free_vld_q ? free_q : scan_q;

  always_comb begin
    state_d = state_q;
    op_d = op_q; pid_d = pid_q; d_d = d_q; p_d = p_q; pred_d = pred_q;
    scan_d = scan_q; free_d = free_q; free_vld_d = free_vld_q;
    d_ra = d_q; nxa_ra = pred_q; nxb_ra = p_q; pid_ra = pid_q; key_ra = scan_q;
    head_we = 1'b0; head_wa = d_q; head_wd = pid_q;
    tail_we = 1'b0; tail_wa = d_q; tail_wd = pid_q;
    next_we = 1'b0; next_wa = pred_q; next_wd = nxb_rd_q;
    pdi_we = 1'b0; pdi_wa = pid_q; pdi_wd = d_q;
    key_we = 1'b0; key_wa = fidx;
    in_use_set = 1'b0; in_use_clr = 1'b0; in_use_idx = d_q;
    blk_set = 1'b0; blk_clr = 1'b0; blk_idx = pid_q;
    out_set = 1'b0;
    res_d = '0;
    pn = p_q;
    case (state_q)
      ST_IDLE: begin
        pid_ra = s_pidx;
        key_ra = '0;
        if (accept) begin
          op_d = s_op;
          pid_d = s_pidx;
          scan_d = '0;
          free_vld_d = 1'b0;
          case (s_op)
            OP_INSERT: begin
              if (!s_pid_ok || blocked_q[s_pidx]) begin
                res_d.refused = 1'b1;
                out_set = 1'b1;
              end else begin
                state_d = ST_SCAN;
              end
            end
            OP_TAKE: begin
              if (s_pid_ok && blocked_q[s_pidx]) begin
                p_d = s_pidx;
                state_d = ST_DESC;
              end else begin
                out_set = 1'b1;
              end
            end
            default: state_d = ST_SCAN;
          endcase
        end
      end
      ST_SCAN: begin
        d_ra = scan_q;
        key_ra = scan_q + 1'b1;
        if (free_here && !free_vld_q) begin
          free_d = scan_q;
          free_vld_d = 1'b1;
        end
        if (hit) begin
          d_d = scan_q;
          state_d = (op_q == OP_INSERT) ? ST_TAIL : ST_HT;
        end else if (scan_q == LastIdx) begin
          state_d = ST_IDLE;
          out_set = 1'b1;
          if (op_q == OP_INSERT) begin
            if (free_vld_q || free_here) begin
              // Allocate the lowest free descriptor with a one-entry queue.
              in_use_set = 1'b1; in_use_idx = fidx;
              key_we = 1'b1;
              head_we = 1'b1; head_wa = fidx;
              tail_we = 1'b1; tail_wa = fidx;
              blk_set = 1'b1;
              pdi_we = 1'b1; pdi_wd = fidx;
            end else begin
              res_d.refused = 1'b1;
            end
          end
        end else begin
          scan_d = scan_q + 1'b1;
        end
      end
      ST_TAIL: begin
        next_we = 1'b1; next_wa = tail_rd_q; next_wd = pid_q;
        tail_we = 1'b1;
        blk_set = 1'b1;
        pdi_we = 1'b1;
        out_set = 1'b1;
        state_d = ST_IDLE;
      end
      ST_DESC: begin
        d_ra = pdi_rd_q;
        d_d = pdi_rd_q;
        state_d = ST_HT;
      end
      ST_HT: begin
        if (op_q == OP_PEEK) begin
          res_d.found = 1'b1;
          res_d.proc_out = PidW'(head_rd_q);
          out_set = 1'b1;
          state_d = ST_IDLE;
        end else begin
          pn = (op_q == OP_REMOVE) ? head_rd_q : p_q;
          p_d = pn;
          nxb_ra = pn;
          nxa_ra = head_rd_q;
          pred_d = head_rd_q;
          scan_d = '0;
          blk_clr = 1'b1; blk_idx = pn;
          if (head_rd_q == pn) begin
            if (tail_rd_q == pn) begin
              in_use_clr = 1'b1;
              res_d.found = 1'b1;
              res_d.proc_out = PidW'(pn);
              out_set = 1'b1;
              state_d = ST_IDLE;
            end else begin
              state_d = ST_HEAD;
            end
          end else begin
            state_d = ST_WALK;
          end
        end
      end
      ST_HEAD: begin
        head_we = 1'b1; head_wd = nxb_rd_q;
        res_d.found = 1'b1;
        res_d.proc_out = PidW'(p_q);
        out_set = 1'b1;
        state_d = ST_IDLE;
      end
      ST_WALK: begin
        if (nxa_rd_q == p_q) begin
          next_we = 1'b1;
          if (tail_rd_q == p_q) begin
            tail_we = 1'b1; tail_wd = pred_q;
          end
          res_d.found = 1'b1;
          res_d.proc_out = PidW'(p_q);
          out_set = 1'b1;
          state_d = ST_IDLE;
        end else if (scan_q == LastIdx) begin
          res_d.found = 1'b1;
          res_d.proc_out = PidW'(p_q);
          out_set = 1'b1;
          state_d = ST_IDLE;
        end else begin
          pred_d = nxa_rd_q;
          nxa_ra = nxa_rd_q;
          scan_d = scan_q + 1'b1;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (head_we) head_mem[head_wa] <= head_wd;
    if (tail_we) tail_mem[tail_wa] <= tail_wd;
    if (next_we) next_mem[next_wa] <= next_wd;
    if (pdi_we)  pdi_mem[pdi_wa]   <= pdi_wd;
    head_rd_q <= head_mem[d_ra];
    tail_rd_q <= tail_mem[d_ra];
    nxa_rd_q  <= next_mem[nxa_ra];
    nxb_rd_q  <= next_mem[nxb_ra];
    pdi_rd_q  <= pdi_mem[pid_ra];
  end

  always_ff @(posedge clk_i) begin
    op_q <= op_d; pid_q <= pid_d; d_q <= d_d; p_q <= p_d; pred_q <= pred_d;
    scan_q <= scan_d; free_q <= free_d;
    if (accept) key_q <= s_key;
    if (out_set) res_q <= res_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      free_vld_q <= 1'b0;
      in_use_q <= '0;
      blocked_q <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      free_vld_q <= free_vld_d;
      if (in_use_set) in_use_q[in_use_idx] <= 1'b1;
      if (in_use_clr) in_use_q[in_use_idx] <= 1'b0;
      if (blk_set) blocked_q[blk_idx] <= 1'b1;
      if (blk_clr) blocked_q[blk_idx] <= 1'b0;
      if (out_set) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {{(OutDataW - 6){1'b0}}, res_q};

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready_o && out_vld_q)) else $error("input taken while a result waits");

  a_accept_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q != ST_IDLE) || out_vld_q) else $error("accepted beat dropped");

  a_one_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> !(res_q.refused && res_q.found)) else $error("refused and found both set");

endmodule

// ----- bench/tb_top.sv -----
// Self-checking testbench for the semaphore wait-queue table.
module tb_top;
  import swqt_pkg::*;

  localparam int unsigned NP = DefNumProcs;
  localparam int unsigned CycleLimit = 400000;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid_i = 1'b0;
  logic                s_axis_tready_o;
  // operation[1:0], sem_key[33:2], proc_id[37:34], zero fill
  logic [InDataW-1:0]  s_axis_tdata_i = '0;
  logic                m_axis_tvalid_o;
  logic                m_axis_tready_i = 1'b0;
  // refused[0], found[1], proc_out[5:2], zero fill
  logic [OutDataW-1:0] m_axis_tdata_o;

  semaphore_wait_queue_table #(.NUM_PROCS(NP)) dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Shadow copy of the descriptor pool and the blocked-process lists.
  logic        sh_in_use  [NP];
  logic [31:0] sh_key     [NP];
  logic [3:0]  sh_head    [NP];
  logic [3:0]  sh_tail    [NP];
  logic [3:0]  sh_next    [NP];
  logic        sh_blocked [NP];
  logic [3:0]  sh_desc    [NP];

  result_t     pending_results[$];
  int          errors = 0;
  int          cycles = 0;
  bit          quiet  = 1'b0;
  logic [31:0] keys_seen[$];

  function automatic int lookup_desc(logic [31:0] key);
    for (int d = 0; d < NP; d++)
      if (sh_in_use[d] && sh_key[d] == key) return d;
    return NP;
  endfunction

  function automatic void unblock(int p);
    int d;
    int pred;
    d = sh_desc[p];
    sh_blocked[p] = 1'b0;
    if (sh_head[d] == p) begin
      if (sh_tail[d] == p) sh_in_use[d] = 1'b0;
      else sh_head[d] = sh_next[p];
      return;
    end
    pred = sh_head[d];
    for (int s = 0; s < NP; s++) begin
      if (sh_next[pred] == p) begin
        sh_next[pred] = sh_next[p];
        if (sh_tail[d] == p) sh_tail[d] = pred[3:0];
        return;
      end
      pred = sh_next[pred];
    end
  endfunction

  function automatic result_t predict_result(op_e op, logic [31:0] key, logic [3:0] pid);
    result_t r;
    int d;
    r = '0;
    case (op)
      OP_INSERT: begin
        if (sh_blocked[pid]) begin
          r.refused = 1'b1;
        end else begin
          d = lookup_desc(key);
          if (d < NP) begin
            sh_next[sh_tail[d]] = pid;
            sh_tail[d] = pid;
          end else begin
            for (d = 0; d < NP; d++) if (!sh_in_use[d]) break;
            if (d < NP) begin
              sh_in_use[d] = 1'b1;
              sh_key[d] = key;
              sh_head[d] = pid;
              sh_tail[d] = pid;
            end
          end
          if (d < NP) begin
            sh_blocked[pid] = 1'b1;
            sh_desc[pid] = d[3:0];
          end else begin
            r.refused = 1'b1;
          end
        end
      end
      OP_TAKE: begin
        if (sh_blocked[pid]) begin
          unblock(pid);
          r.found = 1'b1;
          r.proc_out = pid;
        end
      end
      default: begin
        d = lookup_desc(key);
        if (d < NP) begin
          r.found = 1'b1;
          r.proc_out = sh_head[d];
          if (op == OP_REMOVE) unblock(sh_head[d]);
        end
      end
    endcase
    return r;
  endfunction

  task automatic send_op(op_e op, logic [31:0] key, logic [3:0] pid);
    while (!quiet && $urandom_range(99) < 22) @(negedge clk_i);
    s_axis_tdata_i  <= {2'b00, pid, key, op};
    s_axis_tvalid_i <= 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    pending_results.push_back(predict_result(op, key, pid));
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b0;
    // The block takes no new beat until its result is consumed, so this costs nothing.
    @(negedge clk_i);
  endtask

  task automatic drain();
    while (pending_results.size() != 0) @(negedge clk_i);
  endtask

  // Receiver stalls are drawn at each falling edge.
  always @(negedge clk_i)
    m_axis_tready_i <= quiet ? 1'b1 : ($urandom_range(99) >= 22);

  always @(posedge clk_i) begin
    result_t got;
    result_t want;
    cycles <= cycles + 1;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got = result_t'(m_axis_tdata_o[5:0]);
      if (pending_results.size() == 0) begin
        $display("%0t: result beat with nothing expected, actual %h", $time, got);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (got.refused !== want.refused) begin
          $display("%0t: refused expected %b actual %b", $time, want.refused, got.refused);
          errors++;
        end
        if (got.found !== want.found) begin
          $display("%0t: found expected %b actual %b", $time, want.found, got.found);
          errors++;
        end
        if (got.proc_out !== want.proc_out) begin
          $display("%0t: proc_out expected %h actual %h", $time, want.proc_out,
                   got.proc_out);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i)
    if (cycles >= CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end

  task automatic test_directed();
    // Misses on an empty table, then the key extremes.
    send_op(OP_TAKE, 32'h0, 4'd3);
    send_op(OP_PEEK, 32'hFFFF_FFFF, 4'd0);
    send_op(OP_REMOVE, 32'h1, 4'd0);
    send_op(OP_INSERT, 32'h0, 4'd0);
    send_op(OP_INSERT, 32'hFFFF_FFFF, 4'd15);
    send_op(OP_INSERT, 32'h0, 4'd5);
    send_op(OP_INSERT, 32'h0, 4'd9);
    send_op(OP_INSERT, 32'h1, 4'd5);       // already blocked
    send_op(OP_PEEK, 32'h0, 4'd0);
    send_op(OP_TAKE, 32'h0, 4'd5);         // middle of a queue
    send_op(OP_TAKE, 32'h0, 4'd9);         // tail of a queue
    send_op(OP_REMOVE, 32'h0, 4'd0);
    send_op(OP_PEEK, 32'h0, 4'd0);         // descriptor freed
    send_op(OP_REMOVE, 32'hFFFF_FFFF, 4'd0);
    send_op(OP_TAKE, 32'h0, 4'd15);        // not blocked any more
  endtask

  task automatic test_pool_full();
    // Every process on its own key exhausts the pool, then the pool empties.
    for (int p = 0; p < NP; p++) send_op(OP_INSERT, 32'h1000 + p, p[3:0]);
    send_op(OP_INSERT, 32'h1000, 4'd0);
    for (int p = NP - 1; p >= 0; p--) send_op(OP_REMOVE, 32'h1000 + p, 4'd0);
    drain();
  endtask

  task automatic test_random(int count, bit no_idle);
    op_e         op;
    logic [31:0] key;
    quiet = no_idle;
    for (int n = 0; n < count; n++) begin
      op = op_e'($urandom_range(3));
      if (keys_seen.size() == 0 || $urandom_range(9) < 2) begin
        key = $urandom_range(9) == 0 ? $urandom() : $urandom_range(5);
        keys_seen.push_back(key);
        if (keys_seen.size() > 8) void'(keys_seen.pop_front());
      end else begin
        key = keys_seen[$urandom_range(keys_seen.size() - 1)];
      end
      // Lean toward inserts so the queues grow long enough to walk.
      if (op != OP_INSERT && $urandom_range(3) == 0) op = OP_INSERT;
      send_op(op, key, 4'($urandom_range(NP - 1)));
    end
    quiet = 1'b0;
  endtask

  initial begin
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    for (int i = 0; i < NP; i++) begin
      sh_in_use[i]  = 1'b0;
      sh_blocked[i] = 1'b0;
    end
    test_directed();
    test_pool_full();
    test_random(300, 1'b0);
    test_random(150, 1'b1);
    test_random(350, 1'b0);
    drain();
    repeat (50) @(posedge clk_i);
    if (errors == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ----- semaphore_wait_queue_table.f -----
hw/rtl/swqt_pkg.sv
hw/rtl/swqt_keymem.sv
hw/rtl/semaphore_wait_queue_table.sv
bench/tb_top.sv
